/* design/cbs_pkg.sv */
package cbs_pkg;

	// Widest frame index and run length over the supported frame-count range (up to 64)
	localparam int IDX_W = 6;
	localparam int LEN_W = 7;

	localparam logic [7:0]  GAIN_RST   = 8'd5;
	localparam logic [15:0] REWARD_RST = 16'd2000;

	localparam logic [7:0] REG_GAIN   = 8'd0;
	localparam logic [7:0] REG_REWARD = 8'd1;

	typedef struct packed {
		logic [7:0] chan_a;
		logic [7:0] chan_b;
		logic [7:0] chan_c;
		logic       last_frame;
	} item_t;

	typedef struct packed {
		logic [15:0] fg_mask;
		logic [3:0]  best_start;
		logic [4:0]  best_length;
		logic        too_many;
	} result_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SORT_RD,
		S_SORT_LATCH,
		S_SORT_SCAN,
		S_SORT_WR,
		S_RUN_INIT,
		S_RUN_RD,
		S_RUN_ACC,
		S_RUN_P1,
		S_RUN_P2,
		S_RUN_DIV,
		S_RUN_DIVW,
		S_RUN_V1,
		S_RUN_V2,
		S_RUN_SQRT,
		S_RUN_SQW,
		S_RUN_G1,
		S_RUN_G2,
		S_RUN_CMP,
		S_MASK_RD,
		S_MASK_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             load_we;
		logic [IDX_W-1:0] addr;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] start;
		logic [LEN_W-1:0] len;
		logic             i_latch;
		logic             rank_clr;
		logic             rank_en;
		logic             j_lt_i;
		logic             sort_wr;
		logic             acc_clr;
		logic             acc_en;
		logic             div_go;
		logic             sqrt_go;
		logic             cmp_en;
		logic             best_clr;
		logic             mask_clr;
		logic             mask_en;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic sqrt_busy;
	} sts_t;

endpackage

/* design/cbs_div.sv */
// Restoring divider, one quotient bit per cycle; dividend must be below divisor << QB
module cbs_div #(
	parameter int DW  = 32,
	parameter int DVW = 8,
	parameter int QB  = 24
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  logic [DW-1:0]  dividend,
	input  logic [DVW-1:0] divisor,
	output logic           busy,
	output logic [QB-1:0]  quot
);

	localparam int CNTW = $clog2(QB + 1);

	logic [DVW-1:0]  rem_q;
	logic [DVW-1:0]  dvs_q;
	logic [QB-1:0]   lo_q;
	logic [CNTW-1:0] cnt_q;
	logic [DVW:0]    trial;
	logic            ge;

	assign trial = {rem_q, lo_q[QB-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (go) begin
			cnt_q <= CNTW'(QB);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= DVW'(dividend[DW-1:QB]);
			lo_q  <= dividend[QB-1:0];
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? DVW'(trial - {1'b0, dvs_q}) : trial[DVW-1:0];
			lo_q  <= {lo_q[QB-2:0], ge};
		end
	end

	assign busy = (cnt_q != '0);
	assign quot = lo_q;

endmodule

/* design/cbs_sqrt.sv */
// Digit-by-digit integer square root, one root bit per cycle
module cbs_sqrt #(
	parameter int RW = 23
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  logic [2*RW-1:0] rad,
	output logic            busy,
	output logic [RW-1:0]   root
);

	localparam int CNTW = $clog2(RW + 1);

	logic [RW:0]     rem_q;
	logic [RW-1:0]   root_q;
	logic [2*RW-1:0] rad_q;
	logic [CNTW-1:0] cnt_q;
	logic [RW+2:0]   t;
	logic [RW+2:0]   trial;
	logic            ge;

	assign t     = {rem_q, rad_q[2*RW-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = t >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (go) begin
			cnt_q <= CNTW'(RW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q  <= '0;
			root_q <= '0;
			rad_q  <= rad;
		end else if (cnt_q != '0) begin
			rem_q  <= ge ? (RW+1)'(t - trial) : (RW+1)'(t);
			root_q <= {root_q[RW-2:0], ge};
			rad_q  <= {rad_q[2*RW-3:0], 2'b00};
		end
	end

	assign busy = (cnt_q != '0);
	assign root = root_q;

endmodule

/* design/cbs_dp.sv */
// Sample stores, rank sort, per-run statistics and cost, best-run tracking, mask build
module cbs_dp #(
	parameter int MAX_FRAMES = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cbs_pkg::item_t         item,
	input  cbs_pkg::cmd_t          cmd,
	input  logic [7:0]             gain,
	input  logic [15:0]            reward,
	output cbs_pkg::sts_t          sts,
	output logic [15:0]            fg_mask,
	output logic [$clog2(MAX_FRAMES)-1:0]   best_s,
	output logic [$clog2(MAX_FRAMES+1)-1:0] best_l
);

	localparam int FW  = $clog2(MAX_FRAMES);
	localparam int LW  = $clog2(MAX_FRAMES + 1);
	localparam int SW  = 8 + LW;
	localparam int QW  = 16 + LW;
	localparam int NW  = 16 + 2 * LW;
	localparam int L2W = 2 * LW;
	localparam int QB  = 24;
	localparam int VW  = 22;
	localparam int RW  = 23;
	localparam int CW  = 32;

	logic [23:0]   samp_mem [MAX_FRAMES];
	logic [23:0]   sorted_mem [MAX_FRAMES];
	logic [FW-1:0] order_mem [MAX_FRAMES];
	logic [23:0]   samp_rd_q;
	logic [23:0]   sorted_rd_q;
	logic [FW-1:0] order_rd_q;
	logic [FW-1:0] addr;

	logic [23:0]   word_i_q;
	logic [FW-1:0] rank_q;

	logic [SW-1:0]  s_q [3];
	logic [QW-1:0]  q_q [3];
	logic [NW-1:0]  lq_s1 [3];
	logic [NW-1:0]  ss_s1 [3];
	logic [L2W-1:0] l2_s1;
	logic [NW-1:0]  num_s2 [3];
	logic [QB-1:0]  var_quot [3];
	logic [3:0]     var_busy;
	logic [QB-1:0]  rew_quot;
	logic [2*VW-1:0] vsq_s3 [3];
	logic [2*RW-1:0] sum_s4;
	logic [RW-1:0]  norm;
	logic           sqrt_busy;
	logic [30:0]    gp_s5;
	logic [CW-1:0]  cost_s6;
	logic [LW-1:0]  len_w;

	logic           have_q;
	logic [CW-1:0]  best_cost_q;
	logic [FW-1:0]  best_s_q;
	logic [LW-1:0]  best_l_q;
	logic [15:0]    mask_q;
	logic [LW:0]    pos_w;
	logic [LW:0]    run_lo;
	logic [LW:0]    run_hi;
	logic           outside;
	logic           key_below;

	assign addr  = cmd.addr[FW-1:0];
	assign len_w = cmd.len[LW-1:0];

	// Memories
	always_ff @(posedge clk) begin
		if (cmd.load_we) begin
			samp_mem[addr] <= {item.chan_c, item.chan_b, item.chan_a};
		end
		samp_rd_q <= samp_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.sort_wr) begin
			sorted_mem[rank_q] <= word_i_q;
		end
		sorted_rd_q <= sorted_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.sort_wr) begin
			order_mem[rank_q] <= cmd.idx[FW-1:0];
		end
		order_rd_q <= order_mem[addr];
	end

	// Rank: keys strictly below, plus equal keys from earlier frames
	assign key_below = (samp_rd_q[7:0] < word_i_q[7:0]) ||
	                   ((samp_rd_q[7:0] == word_i_q[7:0]) && cmd.j_lt_i);

	always_ff @(posedge clk) begin
		if (cmd.i_latch) begin
			word_i_q <= samp_rd_q;
		end
		if (cmd.rank_clr) begin
			rank_q <= '0;
		end else if (cmd.rank_en && key_below) begin
			rank_q <= rank_q + 1'b1;
		end
	end

	// Running sums and free-running arithmetic stages
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			if (cmd.acc_clr) begin
				s_q[c] <= '0;
				q_q[c] <= '0;
			end else if (cmd.acc_en) begin
				s_q[c] <= s_q[c] + SW'(sorted_rd_q[8*c +: 8]);
				q_q[c] <= q_q[c] + QW'(16'(sorted_rd_q[8*c +: 8]) * 16'(sorted_rd_q[8*c +: 8]));
			end
			lq_s1[c]  <= NW'(len_w) * NW'(q_q[c]);
			ss_s1[c]  <= NW'(s_q[c]) * NW'(s_q[c]);
			num_s2[c] <= lq_s1[c] - ss_s1[c];
			vsq_s3[c] <= (2*VW)'(var_quot[c][VW-1:0]) * (2*VW)'(var_quot[c][VW-1:0]);
		end
		l2_s1   <= L2W'(len_w) * L2W'(len_w);
		sum_s4  <= (2*RW)'(vsq_s3[0]) + (2*RW)'(vsq_s3[1]) + (2*RW)'(vsq_s3[2]);
		gp_s5   <= 31'(gain) * 31'(norm);
		cost_s6 <= CW'(gp_s5) + CW'(rew_quot);
	end

	for (genvar c = 0; c < 3; c++) begin : g_var_div
		cbs_div #(
			.DW  (NW + 8),
			.DVW (L2W),
			.QB  (QB)
		) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.go       (cmd.div_go),
			.dividend ({num_s2[c], 8'b0}),
			.divisor  (l2_s1),
			.busy     (var_busy[c]),
			.quot     (var_quot[c])
		);
	end

	cbs_div #(
		.DW  (25),
		.DVW (L2W),
		.QB  (QB)
	) u_rew_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend ({1'b0, reward, 8'b0}),
		.divisor  (l2_s1),
		.busy     (var_busy[3]),
		.quot     (rew_quot)
	);

	cbs_sqrt #(
		.RW (RW)
	) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.sqrt_go),
		.rad    (sum_s4),
		.busy   (sqrt_busy),
		.root   (norm)
	);

	assign sts.div_busy  = |var_busy;
	assign sts.sqrt_busy = sqrt_busy;

	// Best run: first one with strictly lowest cost wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (cmd.best_clr) begin
			have_q <= 1'b0;
		end else if (cmd.cmp_en) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cmp_en && (!have_q || cost_s6 < best_cost_q)) begin
			best_cost_q <= cost_s6;
			best_s_q    <= cmd.start[FW-1:0];
			best_l_q    <= len_w;
		end
	end

	// Foreground mask over sorted positions outside the chosen run
	assign pos_w   = (LW+1)'(cmd.idx[FW-1:0]);
	assign run_lo  = (LW+1)'(best_s_q);
	assign run_hi  = run_lo + (LW+1)'(best_l_q);
	assign outside = (pos_w < run_lo) || (pos_w >= run_hi);

	always_ff @(posedge clk) begin
		if (cmd.mask_clr) begin
			mask_q <= '0;
		end else if (cmd.mask_en && outside) begin
			mask_q <= mask_q | (16'(1) << order_rd_q);
		end
	end

	assign fg_mask = mask_q;
	assign best_s  = best_s_q;
	assign best_l  = best_l_q;

endmodule

/* design/cbs_ctrl.sv */
// Sequencer: frame load, rank sort, run sweep, mask pass, result strobe
module cbs_ctrl #(
	parameter int MAX_FRAMES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          last_frame,
	input  cbs_pkg::sts_t sts,
	output cbs_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done,
	output logic          too_many
);

	localparam int FW = $clog2(MAX_FRAMES);
	localparam int LW = $clog2(MAX_FRAMES + 1);

	cbs_pkg::state_t state_q, state_d;
	logic [LW-1:0] cnt_q, cnt_d;
	logic          ovf_q, ovf_d;
	logic [FW-1:0] i_q, i_d;
	logic [FW-1:0] j_q, j_d;
	logic [FW-1:0] start_q, start_d;
	logic [LW-1:0] len_q, len_d;
	logic [LW-1:0] n_m1;
	logic [LW:0]   run_end;
	logic          i_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbs_pkg::S_IDLE;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			start_q <= '0;
			len_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ovf_q   <= ovf_d;
			i_q     <= i_d;
			j_q     <= j_d;
			start_q <= start_d;
			len_q   <= len_d;
		end
	end

	assign n_m1    = cnt_q - 1'b1;
	assign i_last  = (LW'(i_q) == n_m1);
	assign run_end = (LW+1)'(start_q) + (LW+1)'(len_q);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		ovf_d   = ovf_q;
		i_d     = i_q;
		j_d     = j_q;
		start_d = start_q;
		len_d   = len_q;
		cmd     = '0;
		unique case (state_q)
			cbs_pkg::S_IDLE: begin
				if (start) begin
					if (cnt_q < LW'(MAX_FRAMES)) begin
						cmd.load_we = 1'b1;
						cmd.addr    = cbs_pkg::IDX_W'(cnt_q);
						cnt_d       = cnt_q + 1'b1;
					end else begin
						ovf_d = 1'b1;
					end
					if (last_frame) begin
						i_d     = '0;
						state_d = cbs_pkg::S_SORT_RD;
					end
				end
			end
			cbs_pkg::S_SORT_RD: begin
				cmd.addr = cbs_pkg::IDX_W'(i_q);
				state_d  = cbs_pkg::S_SORT_LATCH;
			end
			cbs_pkg::S_SORT_LATCH: begin
				cmd.i_latch  = 1'b1;
				cmd.rank_clr = 1'b1;
				j_d          = '0;
				state_d      = cbs_pkg::S_SORT_SCAN;
			end
			cbs_pkg::S_SORT_SCAN: begin
				cmd.rank_en = 1'b1;
				cmd.j_lt_i  = (j_q < i_q);
				if (LW'(j_q) == n_m1) begin
					state_d = cbs_pkg::S_SORT_WR;
				end else begin
					cmd.addr = cbs_pkg::IDX_W'(j_q + 1'b1);
					j_d      = j_q + 1'b1;
				end
			end
			cbs_pkg::S_SORT_WR: begin
				cmd.sort_wr = 1'b1;
				cmd.idx     = cbs_pkg::IDX_W'(i_q);
				if (i_last) begin
					start_d = '0;
					state_d = cbs_pkg::S_RUN_INIT;
				end else begin
					i_d     = i_q + 1'b1;
					state_d = cbs_pkg::S_SORT_RD;
				end
			end
			cbs_pkg::S_RUN_INIT: begin
				cmd.acc_clr = 1'b1;
				len_d       = LW'(1);
				state_d     = cbs_pkg::S_RUN_RD;
			end
			cbs_pkg::S_RUN_RD: begin
				cmd.addr = cbs_pkg::IDX_W'(run_end - 1'b1);
				state_d  = cbs_pkg::S_RUN_ACC;
			end
			cbs_pkg::S_RUN_ACC: begin
				cmd.acc_en = 1'b1;
				state_d    = cbs_pkg::S_RUN_P1;
			end
			cbs_pkg::S_RUN_P1: state_d = cbs_pkg::S_RUN_P2;
			cbs_pkg::S_RUN_P2: state_d = cbs_pkg::S_RUN_DIV;
			cbs_pkg::S_RUN_DIV: begin
				cmd.div_go = 1'b1;
				state_d    = cbs_pkg::S_RUN_DIVW;
			end
			cbs_pkg::S_RUN_DIVW: begin
				if (!sts.div_busy) begin
					state_d = cbs_pkg::S_RUN_V1;
				end
			end
			cbs_pkg::S_RUN_V1: state_d = cbs_pkg::S_RUN_V2;
			cbs_pkg::S_RUN_V2: state_d = cbs_pkg::S_RUN_SQRT;
			cbs_pkg::S_RUN_SQRT: begin
				cmd.sqrt_go = 1'b1;
				state_d     = cbs_pkg::S_RUN_SQW;
			end
			cbs_pkg::S_RUN_SQW: begin
				if (!sts.sqrt_busy) begin
					state_d = cbs_pkg::S_RUN_G1;
				end
			end
			cbs_pkg::S_RUN_G1: state_d = cbs_pkg::S_RUN_G2;
			cbs_pkg::S_RUN_G2: state_d = cbs_pkg::S_RUN_CMP;
			cbs_pkg::S_RUN_CMP: begin
				cmd.cmp_en = 1'b1;
				if (run_end < (LW+1)'(cnt_q)) begin
					len_d   = len_q + 1'b1;
					state_d = cbs_pkg::S_RUN_RD;
				end else if (LW'(start_q) == n_m1) begin
					state_d = cbs_pkg::S_MASK_RD;
				end else begin
					start_d = start_q + 1'b1;
					state_d = cbs_pkg::S_RUN_INIT;
				end
			end
			cbs_pkg::S_MASK_RD: begin
				cmd.mask_clr = 1'b1;
				i_d          = '0;
				state_d      = cbs_pkg::S_MASK_SCAN;
			end
			cbs_pkg::S_MASK_SCAN: begin
				cmd.mask_en = 1'b1;
				cmd.idx     = cbs_pkg::IDX_W'(i_q);
				if (i_last) begin
					state_d = cbs_pkg::S_DONE;
				end else begin
					cmd.addr = cbs_pkg::IDX_W'(i_q + 1'b1);
					i_d      = i_q + 1'b1;
				end
			end
			cbs_pkg::S_DONE: begin
				cmd.best_clr = 1'b1;
				cnt_d        = '0;
				ovf_d        = 1'b0;
				state_d      = cbs_pkg::S_IDLE;
			end
			default: state_d = cbs_pkg::S_IDLE;
		endcase
		cmd.start = cbs_pkg::IDX_W'(start_q);
		cmd.len   = cbs_pkg::LEN_W'(len_q);
	end

	assign busy     = (state_q != cbs_pkg::S_IDLE);
	assign done     = (state_q == cbs_pkg::S_DONE);
	assign too_many = ovf_q;

endmodule

/* design/consensus_background_selector_unit.sv */
// Frame beats are taken one per cycle while idle; the beat with last_frame starts scoring.
// Scoring n frames runs a rank sort, one setup step per run start plus, for each of the
// n*(n+1)/2 runs, a bit-serial divide and a bit-serial square root, and then a mask build
// ending in the one-cycle done strobe.
// busy stays high through done. Results cannot be stalled.
// Reset clears control state and loads the default registers.
module consensus_background_selector_unit #(
	parameter int MAX_FRAMES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cbs_pkg::item_t   item,
	output logic             done,
	output cbs_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [7:0]       cfg_index,
	input  logic [15:0]      cfg_data
);

	localparam int FW = $clog2(MAX_FRAMES);
	localparam int LW = $clog2(MAX_FRAMES + 1);

	logic [7:0]    gain_q;
	logic [15:0]   reward_q;
	cbs_pkg::cmd_t cmd;
	cbs_pkg::sts_t sts;
	logic          too_many;
	logic [15:0]   fg_mask;
	logic [FW-1:0] best_s;
	logic [LW-1:0] best_l;

	// Config writes are held off while a set is being scored.
	assign cfg_ready = ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= cbs_pkg::GAIN_RST;
			reward_q <= cbs_pkg::REWARD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cbs_pkg::REG_GAIN:   gain_q   <= cfg_data[7:0];
				cbs_pkg::REG_REWARD: reward_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer: owns frame count, overflow flag and all loop counters
	cbs_ctrl #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.last_frame (item.last_frame),
		.sts        (sts),
		.cmd        (cmd),
		.busy       (busy),
		.done       (done),
		.too_many   (too_many)
	);

	// Datapath: sample memories, statistics, dividers, square root, best run, mask
	cbs_dp #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.cmd     (cmd),
		.gain    (gain_q),
		.reward  (reward_q),
		.sts     (sts),
		.fg_mask (fg_mask),
		.best_s  (best_s),
		.best_l  (best_l)
	);

	// Result fields are held registers; valid during the done beat.
	assign result.fg_mask     = fg_mask;
	assign result.best_start  = 4'(best_s);
	assign result.best_length = 5'(best_l);
	assign result.too_many    = too_many;

endmodule
